FILE: hdl/software_timer_slot_table_macros.svh
// Assertion macros shared by the timer slot table RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define STST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define STST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define STST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define STST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/stst_pkg.sv
// Types and constants for the timer slot table.
// No dependencies.
package stst_pkg;

  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MASK_W      = 15;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [ACT_W-1:0] {
    ACT_START  = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One timer entry as held in the slot memory.
  typedef struct packed {
    logic [COUNT_W-1:0] delay;
    logic [COUNT_W-1:0] start;
  } slot_entry_t;

endpackage

FILE: hdl/software_timer_slot_table.sv
// Timer slot table top level: sequencer, busy bits, counter and output register.
// Cancel and read go straight to the result; start probes the slots in turn from slot 1,
// tick reads and compares each slot from slot 1 up. A transaction is taken only in idle,
// once the last result is in the output register; input is taken again while a result
// waits at the output. Reset (rst_ni low, async) clears counter, busy bits, output valid.
// Depends on stst_pkg, stst_slot_ram, stst_expiry_unit and the macros header.
module software_timer_slot_table #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: delay_ticks[31:0], slot[35:32], zero fill [39:36]
  input  logic [stst_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [stst_pkg::ACT_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: assigned_slot[3:0], table_full[4], expired_mask[19:5], count_now[51:20],
  //        zero fill [55:52]
  output logic [stst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import stst_pkg::*;
  `include "software_timer_slot_table_macros.svh"

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOT_COUNT - 1);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [COUNT_W-1:0]   delay_q, delay_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                 res_full_q, res_full_d;
  logic [MASK_W-1:0]    res_mask_q, res_mask_d;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 s_accept;
  action_e              in_action;
  logic [COUNT_W-1:0]   in_delay;
  logic [SLOT_W-1:0]    in_slot;

  logic                 mem_we;
  slot_entry_t          mem_wdata;
  slot_entry_t          mem_rdata;
  logic                 expired;

  assign in_action = action_e'(s_axis_tuser_i);
  assign in_delay  = s_axis_tdata_i[COUNT_W-1:0];
  assign in_slot   = s_axis_tdata_i[COUNT_W+SLOT_W-1:COUNT_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign mem_wdata.delay = delay_q;
  assign mem_wdata.start = count_q;

  stst_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(idx_q),
    .wdata_i(mem_wdata),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  stst_expiry_unit u_expiry (
    .count_i  (count_q),
    .entry_i  (mem_rdata),
    .expired_o(expired)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    busy_d     = busy_q;
    count_d    = count_q;
    delay_d    = delay_q;
    res_slot_d = res_slot_q;
    res_full_d = res_full_q;
    res_mask_d = res_mask_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    mem_we     = 1'b0;

    // Compare stage: registered read data belongs to pend_idx_q.
    if (pend_q && busy_q[pend_idx_q] && expired) begin
      busy_d[pend_idx_q] = 1'b0;
      for (int k = 0; k < MASK_W; k++) begin
        if (7'(pend_idx_q) == 7'(k + 1)) begin
          res_mask_d[k] = 1'b1;
        end
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          res_slot_d = '0;
          res_full_d = 1'b0;
          res_mask_d = '0;
          idx_d      = IDX_FIRST;
          case (in_action)
            ACT_START: begin
              delay_d = in_delay;
              state_d = ST_FIND;
            end
            ACT_CANCEL: begin
              if (in_slot != '0 && {3'b000, in_slot} < 7'(SLOT_COUNT)) begin
                busy_d[IDX_W'(in_slot)] = 1'b0;
              end
              state_d = ST_DONE;
            end
            ACT_TICK: begin
              count_d = count_q + 32'd1;
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (!busy_q[idx_q]) begin
          mem_we        = 1'b1;
          busy_d[idx_q] = 1'b1;
          res_slot_d    = SLOT_W'(idx_q);
          state_d       = ST_DONE;
        end else if (idx_q == IDX_LAST) begin
          res_full_d = 1'b1;
          state_d    = ST_DONE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        pend_d     = 1'b1;
        pend_idx_d = idx_q;
        if (idx_q == IDX_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0000, count_q, res_mask_q, res_full_q, res_slot_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      busy_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      busy_q    <= busy_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    delay_q    <= delay_d;
    res_slot_q <= res_slot_d;
    res_full_q <= res_full_d;
    res_mask_q <= res_mask_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `STST_ASSERT_IMP(a_slot0_never_busy, clk_i, rst_ni, 1'b1, !busy_q[0], "slot 0 became busy")
  `STST_ASSERT_NXT(a_tick_advances, clk_i, rst_ni, s_accept && in_action == ACT_TICK,
                   count_q == $past(count_q) + 32'd1, "tick did not advance counter")
  `STST_ASSERT_IMP(a_full_no_slot, clk_i, rst_ni, m_valid_q && m_data_q[SLOT_W],
                   m_data_q[SLOT_W-1:0] == '0, "full result carries a slot")

endmodule

FILE: hdl/stst_slot_ram.sv
// Slot entry memory: one write port, one registered read port.
// Depends on stst_pkg.
module stst_slot_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  stst_pkg::slot_entry_t wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output stst_pkg::slot_entry_t rdata_o
);
  import stst_pkg::*;

  slot_entry_t mem_q [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/stst_expiry_unit.sv
// Shared expiry check: elapsed = now - start (mod 2^32), expired when >= delay.
// Depends on stst_pkg.
module stst_expiry_unit (
  input  logic [stst_pkg::COUNT_W-1:0] count_i,
  input  stst_pkg::slot_entry_t        entry_i,
  output logic                         expired_o
);
  import stst_pkg::*;

  logic [COUNT_W-1:0] elapsed;

  assign elapsed   = count_i - entry_i.start;
  assign expired_o = (elapsed >= entry_i.delay);

endmodule

FILE: verif/software_timer_slot_table_tb.sv
// Self-checking testbench for software_timer_slot_table: stream stimulus, result checks.
// Depends on stst_pkg and the software_timer_slot_table RTL with its submodules and macros header.
module software_timer_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stst_pkg::*;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned IDLE_LIMIT  = 4000;  // cycles with no transaction on either side
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned RAND_ROUNDS = 7;
  localparam int unsigned ROUND_ITEMS = 250;

  // Reply fields, last field in the lowest bits as on m_axis_tdata_o.
  typedef struct packed {
    logic [COUNT_W-1:0] count_now;
    logic [MASK_W-1:0]  expired_mask;
    logic               table_full;
    logic [SLOT_W-1:0]  assigned_slot;
  } timer_reply_t;

  // Mirror of the timer table plus the replies still owed by the block.
  class timer_table_tracker;
    bit [COUNT_W-1:0] ticks;
    bit               busy[TABLE_SLOTS];
    bit [COUNT_W-1:0] armed_at[TABLE_SLOTS];
    bit [COUNT_W-1:0] wait_len[TABLE_SLOTS];
    timer_reply_t     pending_replies[$];
    int unsigned      errors, replies_seen;
    int unsigned      n_starts, n_full, n_ticks, n_expired, n_cancel_hits, n_reads;

    function new();
      ticks = '0;
      foreach (busy[i]) busy[i] = 1'b0;
    endfunction

    function timer_reply_t apply_request(action_e act, bit [COUNT_W-1:0] delay,
                                         bit [SLOT_W-1:0] slot);
      timer_reply_t reply;
      int           free_slot;
      reply     = '0;
      free_slot = 0;
      case (act)
        ACT_START: begin
          n_starts++;
          for (int i = 1; i < TABLE_SLOTS; i++) begin
            if (!busy[i] && free_slot == 0) free_slot = i;
          end
          if (free_slot == 0) begin
            reply.table_full = 1'b1;
            n_full++;
          end else begin
            busy[free_slot]     = 1'b1;
            armed_at[free_slot] = ticks;
            wait_len[free_slot] = delay;
            reply.assigned_slot = free_slot[SLOT_W-1:0];
          end
        end
        ACT_CANCEL: begin
          if (slot != 0 && slot < TABLE_SLOTS) begin
            if (busy[slot]) n_cancel_hits++;
            busy[slot] = 1'b0;
          end
        end
        ACT_TICK: begin
          n_ticks++;
          ticks = ticks + 1;
          for (int i = 1; i < TABLE_SLOTS; i++) begin
            // elapsed count is modulo 2^32 by the width of the subtraction
            if (busy[i] && COUNT_W'(ticks - armed_at[i]) >= wait_len[i]) begin
              busy[i] = 1'b0;
              reply.expired_mask[i-1] = 1'b1;
              n_expired++;
            end
          end
        end
        default: n_reads++;
      endcase
      reply.count_now = ticks;
      return reply;
    endfunction

    function void note_request(action_e act, bit [COUNT_W-1:0] delay, bit [SLOT_W-1:0] slot);
      pending_replies.push_back(apply_request(act, delay, slot));
    endfunction

    function void flag(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] tdata);
      timer_reply_t want, got;
      got = tdata[$bits(timer_reply_t)-1:0];
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, actual %0h", $time, tdata);
        return;
      end
      want = pending_replies.pop_front();
      replies_seen++;
      if (got.assigned_slot !== want.assigned_slot)
        flag("assigned_slot", want.assigned_slot, got.assigned_slot);
      if (got.table_full !== want.table_full)
        flag("table_full", want.table_full, got.table_full);
      if (got.expired_mask !== want.expired_mask)
        flag("expired_mask", want.expired_mask, got.expired_mask);
      if (got.count_now !== want.count_now)
        flag("count_now", want.count_now, got.count_now);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [ACT_W-1:0]       s_axis_tuser_i = ACT_READ;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  timer_table_tracker tracker = new();
  int unsigned        idle_cycles = 0;

  software_timer_slot_table #(
    .SLOT_COUNT(TABLE_SLOTS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Transactions on both sides, plus the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        tracker.note_request(action_e'(s_axis_tuser_i), s_axis_tdata_i[COUNT_W-1:0],
                             s_axis_tdata_i[COUNT_W+SLOT_W-1:COUNT_W]);
      if (m_axis_tvalid_o && m_axis_tready_i) tracker.check_reply(m_axis_tdata_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: segments of varying readiness, one long hold-off mid-run.
  initial begin
    int unsigned seg_len, ready_pct;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && tracker.replies_seen >= 700) begin
        held = 1'b1;
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 75;
        2:       ready_pct = 40;
        default: ready_pct = 10;
      endcase
      seg_len = $urandom_range(10, 120);
      repeat (seg_len) begin
        @(negedge clk_i);
        m_axis_tready_i <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  task automatic offer_request(action_e act, bit [COUNT_W-1:0] delay, bit [SLOT_W-1:0] slot);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W-COUNT_W-SLOT_W){1'b0}}, slot, delay};
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_replies();
    sender_gap(0);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // mode 0 balanced, 1 start-heavy (fills the table), 2 tick-heavy
  task automatic random_request(int unsigned mode);
    action_e          act;
    bit [COUNT_W-1:0] delay;
    int unsigned      pick, d;
    int unsigned      start_cut, cancel_cut, tick_cut;
    pick = $urandom_range(0, 99);
    d    = $urandom_range(0, 99);
    case (mode)
      1:       begin start_cut = 55; cancel_cut = 62; tick_cut = 92; end
      2:       begin start_cut = 25; cancel_cut = 35; tick_cut = 95; end
      default: begin start_cut = 35; cancel_cut = 55; tick_cut = 90; end
    endcase
    if (pick < start_cut)       act = ACT_START;
    else if (pick < cancel_cut) act = ACT_CANCEL;
    else if (pick < tick_cut)   act = ACT_TICK;
    else                        act = ACT_READ;
    if (d < 55)      delay = $urandom_range(0, 6);
    else if (d < 85) delay = $urandom_range(0, 40);
    else             delay = $urandom();
    offer_request(act, delay, SLOT_W'($urandom_range(0, 15)));
  endtask

  initial begin
    int unsigned mode, burst;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero delay, cancels of slot 0 / busy / free slots, full table, top slot
    offer_request(ACT_READ, '1, 4'd15);
    offer_request(ACT_START, '0, 4'd0);
    offer_request(ACT_TICK, '0, 4'd0);
    offer_request(ACT_START, 32'd3, 4'd0);
    offer_request(ACT_CANCEL, '0, 4'd1);
    offer_request(ACT_CANCEL, '0, 4'd0);
    offer_request(ACT_CANCEL, '1, 4'd7);
    repeat (TABLE_SLOTS - 1) offer_request(ACT_START, '1, 4'd0);
    offer_request(ACT_START, 32'd1, 4'd0);
    offer_request(ACT_TICK, '0, 4'd0);
    offer_request(ACT_CANCEL, '0, 4'd15);
    offer_request(ACT_START, 32'd1, 4'd0);
    wait_all_replies();

    for (int r = 0; r < RAND_ROUNDS; r++) begin
      mode = $urandom_range(0, 2);
      for (int n = 0; n < ROUND_ITEMS; n += burst) begin
        burst = $urandom_range(1, 30);
        repeat (burst) random_request(mode);
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(0, 20));
      end
      if (r == 5) wait_all_replies();
    end

    wait_all_replies();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d replies: %0d starts (%0d on a full table), %0d ticks,",
             tracker.replies_seen, tracker.n_starts, tracker.n_full, tracker.n_ticks);
    $display("  %0d timer expiries, %0d cancels of running timers, %0d counter reads",
             tracker.n_expired, tracker.n_cancel_hits, tracker.n_reads);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
